FILE: hw/rtl/oaht_pkg.sv
`timescale 1ns / 1ps

package oaht_pkg;

  localparam int SLOTS  = 1024;
  localparam int SLOT_W = 10;
  localparam int CNT_W  = 11;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

  // One table slot
  typedef struct packed {
    logic             occ;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  // Incoming request
  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] home;
    logic [VAL_W-1:0]  value;
  } req_t;

  // Result of one request
  typedef struct packed {
    status_t           status;
    logic [VAL_W-1:0]  value_out;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  entry_count;
  } res_t;

  // Memory port controls
  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
  } mem_req_t;

endpackage

FILE: hw/rtl/open_addressing_hash_table_top.sv
`timescale 1ns / 1ps
// Lookup/remove/insert read one slot per cycle through the single memory read port;
// clear writes one slot per cycle. One request at a time: the next is taken once the
// result moves to the output register. Reset (rst, synchronous) runs a clearing pass
// over all 1024 slots of the table with s_tready low; no result comes from it.

module open_addressing_hash_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // key[31:0], home_slot[41:32], value[73:42], zero fill
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // value_out[31:0], slot[41:32], entry_count[52:42], zero fill
  output logic [1:0]  m_tuser    // status[1:0]
);
  import oaht_pkg::*;

  req_t     in_req;
  res_t     res;
  res_t     out_res;
  logic     res_valid;
  logic     res_ready;
  mem_req_t mem_req;
  entry_t   rd_data;

  // Unpack request
  always_comb begin
    in_req.op    = op_t'(s_tuser);
    in_req.key   = s_tdata[31:0];
    in_req.home  = s_tdata[41:32];
    in_req.value = s_tdata[73:42];
  end

  oaht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (in_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  oaht_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // Output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.status;
  assign m_tdata = {3'b000, out_res.entry_count, out_res.slot, out_res.value_out};

endmodule

FILE: hw/rtl/oaht_store.sv
`timescale 1ns / 1ps

module oaht_store (
  input  logic              clk,
  input  oaht_pkg::mem_req_t mem_req,
  output oaht_pkg::entry_t  rd_data
);
  import oaht_pkg::*;

  entry_t mem [SLOTS];

  // Write port
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data <= mem[mem_req.raddr];
    end
  end

endmodule

FILE: hw/rtl/oaht_ctrl.sv
`timescale 1ns / 1ps

module oaht_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  oaht_pkg::req_t     in_req,
  output logic               res_valid,
  input  logic               res_ready,
  output oaht_pkg::res_t     res,
  output oaht_pkg::mem_req_t mem_req,
  input  oaht_pkg::entry_t   rd_data
);
  import oaht_pkg::*;

  state_t            state, state_next;
  req_t              req;
  logic [SLOT_W:0]   k;         // probe index, also sweep address
  logic [SLOT_W-1:0] pos;       // next slot to read
  logic [SLOT_W-1:0] rd_pos;    // slot whose data is on rd_data
  logic              rd_valid;
  logic [CNT_W-1:0]  count, count_next;
  logic              clr_report;
  res_t              res_next;
  logic              match, hit, miss;

  // Probe compare on the data read last cycle
  always_comb begin
    if (req.op == OP_INSERT) begin
      match = !rd_data.occ;
    end else begin
      match = rd_data.occ && (rd_data.key == req.key);
    end
    hit  = (state == S_PROBE) && rd_valid && match;
    miss = (state == S_PROBE) && !rd_valid && k[SLOT_W];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (k[SLOT_W-1:0] == SLOT_W'(SLOTS - 1)) begin
          state_next = clr_report ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = (in_req.op == OP_CLEAR) ? S_CLEAR : S_PROBE;
        end
      end
      S_PROBE: begin
        if (hit || miss) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: handshakes, memory controls, result
  always_comb begin
    in_ready      = (state == S_IDLE);
    res_valid     = (state == S_DONE);
    mem_req       = '0;
    mem_req.re    = (state == S_PROBE) && !k[SLOT_W];
    mem_req.raddr = pos;
    res_next      = '0;
    count_next    = count;
    case (state)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = k[SLOT_W-1:0];
      end
      S_PROBE: begin
        if (hit) begin
          res_next.slot = rd_pos;
          case (req.op)
            OP_INSERT: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = rd_pos;
              mem_req.wdata = '{occ: 1'b1, key: req.key, value: req.value};
              count_next    = count + CNT_W'(1);
            end
            OP_REMOVE: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = rd_pos;
              mem_req.wdata = '{occ: 1'b0, key: rd_data.key, value: rd_data.value};
              if (count != '0) begin
                count_next = count - CNT_W'(1);
              end
            end
            default: begin
              res_next.value_out = rd_data.value;
            end
          endcase
        end else if (miss) begin
          res_next.status = (req.op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
        end
        res_next.entry_count = count_next;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      k          <= '0;
      rd_valid   <= 1'b0;
      count      <= '0;
      clr_report <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: begin
          k <= k + (SLOT_W+1)'(1);
        end
        S_IDLE: begin
          k        <= '0;
          rd_valid <= 1'b0;
          if (in_valid && in_req.op == OP_CLEAR) begin
            clr_report <= 1'b1;
            count      <= '0;
          end
        end
        S_PROBE: begin
          rd_valid <= mem_req.re;
          if (mem_req.re) begin
            k <= k + (SLOT_W+1)'(1);
          end
          count <= count_next;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          req <= in_req;
          pos <= in_req.home;
          res <= '0;
        end
      end
      S_PROBE: begin
        if (mem_req.re) begin
          pos    <= pos + k[SLOT_W-1:0];
          rd_pos <= pos;
        end
        if (hit || miss) begin
          res <= res_next;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: dv/open_addressing_hash_table_top_test.sv
`timescale 1ns / 1ps

module open_addressing_hash_table_top_test;
  import oaht_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 560;
  localparam int unsigned CYCLE_LIMIT     = 8_000_000;
  localparam int unsigned DRAIN_CYCLES    = 1100;
  localparam int unsigned KEY_POOL        = 24;

  // Shadow copy of the table: predicts each result from the accepted requests
  class hash_table_shadow;
    bit               occ [SLOTS];
    logic [KEY_W-1:0] keys [SLOTS];
    logic [VAL_W-1:0] vals [SLOTS];
    int unsigned      live;
    res_t             expected_results [$];
    int unsigned      mismatches;

    function new();
      foreach (occ[i]) occ[i] = 1'b0;
      live       = 0;
      mismatches = 0;
    endfunction

    // First slot on the triangular walk from home that is empty (want_empty)
    // or holds key; -1 when the walk finds none
    function int walk(logic [SLOT_W-1:0] home, logic [KEY_W-1:0] key, bit want_empty);
      int unsigned pos;
      int          k;
      pos = home % SLOTS;
      for (k = 0; k < SLOTS; k++) begin
        if (want_empty ? !occ[pos] : (occ[pos] && keys[pos] == key))
          return pos;
        pos = (pos + k) % SLOTS;
      end
      return -1;
    endfunction

    function void apply_request(op_t op, logic [KEY_W-1:0] key, logic [SLOT_W-1:0] home,
                                logic [VAL_W-1:0] value);
      res_t r;
      int   hit;
      r        = '0;
      r.status = ST_DONE;
      case (op)
        OP_CLEAR: begin
          foreach (occ[i]) occ[i] = 1'b0;
          live = 0;
        end
        OP_INSERT: begin
          hit = walk(home, key, 1'b1);
          if (hit < 0) begin
            r.status = ST_FULL;
          end else begin
            occ[hit]  = 1'b1;
            keys[hit] = key;
            vals[hit] = value;
            live++;
            r.slot = hit[SLOT_W-1:0];
          end
        end
        default: begin
          hit = walk(home, key, 1'b0);
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else if (op == OP_LOOKUP) begin
            r.value_out = vals[hit];
            r.slot      = hit[SLOT_W-1:0];
          end else begin
            occ[hit] = 1'b0;
            if (live > 0) live--;
            r.slot = hit[SLOT_W-1:0];
          end
        end
      endcase
      r.entry_count = live[CNT_W-1:0];
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(status_t status, logic [VAL_W-1:0] value_out,
                               logic [SLOT_W-1:0] slot, logic [CNT_W-1:0] entry_count);
      res_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual status %0d slot %0d",
                 $time, status, slot);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", 32'(want.status), 32'(status));
      compare_field("value_out", want.value_out, value_out);
      compare_field("slot", 32'(want.slot), 32'(slot));
      compare_field("entry_count", 32'(want.entry_count), 32'(entry_count));
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata  = '0;  // key[31:0], home_slot[41:32], value[73:42], zero fill
  logic [1:0]  s_tuser  = '0;  // op[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // value_out[31:0], slot[41:32], entry_count[52:42], zero fill
  logic [1:0]  m_tuser;        // status[1:0]

  hash_table_shadow shadow;
  req_t             request_queue [$];
  int unsigned      cycle_count = 0;
  int unsigned      stall_left  = 0;
  int unsigned      run_left    = 0;

  open_addressing_hash_table_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: ready runs broken by stalls of random length
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (run_left != 0) begin
      m_tready <= 1'b1;
      run_left <= run_left - 1;
    end else begin
      m_tready   <= 1'b1;
      run_left   <= $urandom_range(0, 40);
      stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end
  end

  // Handshake monitor on both sides
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        shadow.apply_request(op_t'(s_tuser), s_tdata[31:0], s_tdata[41:32], s_tdata[73:42]);
      if (m_tvalid && m_tready)
        shadow.check_result(status_t'(m_tuser), m_tdata[31:0], m_tdata[41:32],
                            m_tdata[52:42]);
    end
  end

  function automatic void add_request(op_t op, logic [KEY_W-1:0] key,
                                      logic [SLOT_W-1:0] home, logic [VAL_W-1:0] value);
    req_t r;
    r.op    = op;
    r.key   = key;
    r.home  = home;
    r.value = value;
    request_queue.push_back(r);
  endfunction

  // Corners: empty table, field extremes, duplicates, walk wrap, skip of a freed slot
  function automatic void build_directed();
    add_request(OP_LOOKUP, 32'h0, 10'h000, 32'h0);
    add_request(OP_REMOVE, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF);
    add_request(OP_INSERT, 32'h0, 10'h000, 32'h0);
    add_request(OP_INSERT, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF);
    add_request(OP_INSERT, 32'h0, 10'h000, 32'h1234_5678);
    add_request(OP_LOOKUP, 32'h0, 10'h000, 32'h0);
    add_request(OP_LOOKUP, 32'hFFFF_FFFF, 10'h3FF, 32'h0);
    add_request(OP_LOOKUP, 32'hFFFF_FFFF, 10'h000, 32'h0);
    add_request(OP_REMOVE, 32'h0, 10'h000, 32'h0);
    add_request(OP_LOOKUP, 32'h0, 10'h000, 32'h0);
    add_request(OP_INSERT, 32'h5555_AAAA, 10'h2AA, 32'hAAAA_5555);
    add_request(OP_INSERT, 32'hAAAA_5555, 10'h155, 32'h5555_AAAA);
    add_request(OP_LOOKUP, 32'h5555_AAAA, 10'h2AA, 32'h0);
    add_request(OP_LOOKUP, 32'hAAAA_5555, 10'h155, 32'h0);
    add_request(OP_REMOVE, 32'h0, 10'h001, 32'h0);
    add_request(OP_CLEAR, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF);
    add_request(OP_LOOKUP, 32'hFFFF_FFFF, 10'h3FF, 32'h0);
    add_request(OP_INSERT, 32'h8000_0001, 10'h200, 32'h8000_0001);
    add_request(OP_REMOVE, 32'h8000_0001, 10'h200, 32'h0);
  endfunction

  // Mostly keys from a small working set hashed into a narrow cluster, so walks
  // collide and grow long; some unknown keys and stray homes as noise
  function automatic void build_random();
    logic [KEY_W-1:0]  pool [KEY_POOL];
    logic [SLOT_W-1:0] base;
    logic [KEY_W-1:0]  k;
    logic [SLOT_W-1:0] h;
    op_t               op;
    int unsigned       pick;
    int unsigned       n;
    foreach (pool[i]) pool[i] = $urandom;
    base = SLOT_W'($urandom);
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if ($urandom_range(0, 79) == 0) begin
        base = SLOT_W'($urandom);
        pool[$urandom_range(0, KEY_POOL - 1)] = $urandom;
      end
      pick = $urandom_range(0, 99);
      if (pick < 34)      op = OP_LOOKUP;
      else if (pick < 71) op = OP_INSERT;
      else if (pick < 98) op = OP_REMOVE;
      else                op = OP_CLEAR;
      k = pool[$urandom_range(0, KEY_POOL - 1)];
      h = base + SLOT_W'((k ^ (k >> 13)) & 32'hF);
      if ($urandom_range(0, 9) == 0) k = $urandom;
      if ($urandom_range(0, 9) == 0) h = SLOT_W'($urandom);
      add_request(op, k, h, $urandom);
    end
  endfunction

  // Present one request and hold it until accepted; valid stays high after
  task automatic send_request(req_t r);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, r.value, r.home, r.key};
    s_tuser  <= r.op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    int unsigned burst;
    int unsigned gap;
    shadow = new();
    build_directed();
    build_random();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Sender: bursts of requests with random gaps, some back to back
    while (request_queue.size() != 0) begin
      burst = $urandom_range(1, 16);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 3);
        default: gap = $urandom_range(1, 20);
      endcase
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      while (burst != 0 && request_queue.size() != 0) begin
        send_request(request_queue.pop_front());
        burst--;
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then watch for stray results
    @(posedge clk);
    while (shadow.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
